// ===== rtl/blake2b_hash_engine_defines.svh =====
// ---------------------------------------------------------------------------
// BLAKE2b hash engine assertion macros
// Clocked, reset-qualified assertion wrappers shared by the checker.
// ---------------------------------------------------------------------------
`ifndef BLAKE2B_HASH_ENGINE_DEFINES_SVH
`define BLAKE2B_HASH_ENGINE_DEFINES_SVH

// property sampled on clk_i, off while rst_ni is low
`define BHE_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication
`define BHE_ASSERT_NEXT(lbl, pre, post, msg) \
  `BHE_ASSERT_CLK(lbl, (pre) |=> (post), msg)

`endif

// ===== rtl/bhe_pkg.sv =====
// ---------------------------------------------------------------------------
// bhe_pkg
// Types, constants and helper functions of the BLAKE2b hash engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhe_pkg;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  localparam logic [63:0] PARAM_BASE   = 64'h0000000001010000;
  localparam int          ROT_1        = 32;
  localparam int          ROT_2        = 24;
  localparam int          ROT_3        = 16;
  localparam int          ROT_4        = 63;
  localparam logic [3:0]  LAST_ROUND   = 4'd11;  // 12 rounds
  localparam logic [3:0]  SIGMA_ROWS   = 4'd10;
  localparam logic [4:0]  BLOCK_WORDS  = 5'd16;
  localparam logic [63:0] KEY_BLOCK_BYTES = 64'd128;
  localparam logic [6:0]  MAX_LEN      = 7'd64;
  localparam logic [6:0]  DIGEST_RESET = 7'd32;

  localparam logic [1:0]  CFG_IDX_DIGEST = 2'd0;
  localparam logic [1:0]  CFG_IDX_KEY    = 2'd1;

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_MSG,
    CMD_FIN
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_INIT,
    ST_MIX,
    ST_FOLD,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_number;
    logic        last_digest_word;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [6:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nb;
    cmd_kind_e   kind;
    logic        key_last;
    logic        finish;
  } cmd_t;

  typedef struct packed {
    logic       restart;
    logic [6:0] digest_len;
    logic [6:0] key_len;
    logic [6:0] digest_len_next;
    logic [6:0] key_len_next;
  } ctrl_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } g_out_t;

  function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [3:0] nb);
    logic [63:0] mask;
    mask = (64'd1 << {nb[2:0], 3'b000}) - 64'd1;
    if (nb >= 4'd8) begin
      return w;
    end
    return w & mask;
  endfunction

  // byte count clamped to one word
  function automatic logic [3:0] clamp_nb(input logic [6:0] n);
    return (n >= 7'd8) ? 4'd8 : n[3:0];
  endfunction

  function automatic logic [63:0] chain_init0(input logic [6:0] dl, input logic [6:0] kl);
    return IV[0] ^ PARAM_BASE ^ {49'd0, kl, 8'd0} ^ {57'd0, dl};
  endfunction

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // one half of G: first half uses rotations 32/24, second 16/63
  function automatic g_out_t g_half(input logic [63:0] a, input logic [63:0] b,
                                    input logic [63:0] c, input logic [63:0] d,
                                    input logic [63:0] x, input logic second);
    g_out_t r;
    r.a = a + b + x;
    r.d = second ? ror64(d ^ r.a, ROT_3) : ror64(d ^ r.a, ROT_1);
    r.c = c + r.d;
    r.b = second ? ror64(b ^ r.c, ROT_4) : ror64(b ^ r.c, ROT_2);
    return r;
  endfunction

endpackage

// ===== rtl/bhe_ifs.sv =====
// ---------------------------------------------------------------------------
// bhe_ifs
// Valid/ready channel interfaces: input words, digest words, config writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bhe_in_if;
  logic               valid;
  logic               ready;
  bhe_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bhe_out_if;
  logic               valid;
  logic               ready;
  bhe_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bhe_cfg_if;
  logic               valid;
  logic               ready;
  bhe_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bhe_fifo.sv =====
// ---------------------------------------------------------------------------
// bhe_fifo
// Small command queue between front and back, flushed on restart.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhe_fifo #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          flush_i,
  input  logic          push_i,
  input  bhe_pkg::cmd_t push_data_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output bhe_pkg::cmd_t pop_data_o,
  input  logic          pop_i
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bhe_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (flush_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= bump(wr_q);
      if (do_pop)  rd_q <= bump(rd_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== rtl/bhe_front.sv =====
// ---------------------------------------------------------------------------
// bhe_front
// Takes input beats, tracks the key phase, masks bytes, builds commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bhe_pkg::ctrl_t ctrl_i,
  bhe_in_if.sink         in_i,
  output logic           push_o,
  output bhe_pkg::cmd_t  cmd_o,
  input  logic           push_ready_i
);
  logic       key_phase_q;
  logic [2:0] key_idx_q;
  logic [3:0] key_words, nb, key_nb;
  logic [6:0] key_rem;
  logic [7:0] kw_sum;
  logic       accept, key_last, eom;

  assign in_i.ready = push_ready_i;
  assign push_o     = in_i.valid;
  assign accept     = in_i.valid && push_ready_i;
  assign eom        = in_i.data.end_of_message;

  assign kw_sum    = {1'b0, ctrl_i.key_len} + 8'd7;
  assign key_words = kw_sum[6:3];
  assign key_rem   = ctrl_i.key_len - {1'b0, key_idx_q, 3'b000};
  assign key_nb    = bhe_pkg::clamp_nb(key_rem);
  assign nb        = (in_i.data.valid_bytes > 4'd8) ? 4'd8 : in_i.data.valid_bytes;
  assign key_last  = (({1'b0, key_idx_q} + 4'd1) >= key_words) || eom;

  always_comb begin
    cmd_o = '0;
    if (key_phase_q) begin
      cmd_o.kind     = bhe_pkg::CMD_KEY;
      cmd_o.word     = bhe_pkg::keep_bytes(in_i.data.data_word, key_nb);
      cmd_o.nb       = key_nb;
      cmd_o.key_last = key_last;
      cmd_o.finish   = eom;
    end else if (nb == 4'd0) begin
      cmd_o.kind   = bhe_pkg::CMD_FIN;
      cmd_o.finish = 1'b1;
    end else begin
      cmd_o.kind   = bhe_pkg::CMD_MSG;
      cmd_o.word   = bhe_pkg::keep_bytes(in_i.data.data_word, nb);
      cmd_o.nb     = nb;
      cmd_o.finish = eom || (nb < 4'd8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_phase_q <= 1'b0;  // reset key length is zero
      key_idx_q   <= '0;
    end else if (ctrl_i.restart) begin
      key_phase_q <= (ctrl_i.key_len_next != '0);
      key_idx_q   <= '0;
    end else if (accept) begin
      if (cmd_o.finish) begin
        key_phase_q <= (ctrl_i.key_len != '0);
        key_idx_q   <= '0;
      end else if (key_phase_q && key_last) begin
        key_phase_q <= 1'b0;
        key_idx_q   <= '0;
      end else if (key_phase_q) begin
        key_idx_q <= key_idx_q + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/bhe_back.sv =====
// ---------------------------------------------------------------------------
// bhe_back
// Block buffer, compression with four half-G units, digest output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bhe_pkg::ctrl_t ctrl_i,
  input  logic           cmd_valid_i,
  input  bhe_pkg::cmd_t  cmd_i,
  output logic           pop_o,
  bhe_out_if.source      out_o
);
  bhe_pkg::back_state_e state_q, state_d;

  logic [63:0] h_q [8];
  logic [63:0] v_q [16];
  logic [63:0] m_q [16];
  logic [63:0] v_mix [16];
  logic [63:0] cnt_q;
  logic [4:0]  fill_q;
  logic        held_q, fin_q, last_q;
  logic [3:0]  round_q, row;
  logic [1:0]  phase_q;
  logic [2:0]  k_q;
  logic        out_valid_q;
  bhe_pkg::out_item_t out_q;

  logic        out_free, emit_go, emit_last;
  logic [7:0]  nw_sum;
  logic [3:0]  nw;
  logic [63:0] emit_word;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign out_free    = !out_valid_q || out_o.ready;
  assign nw_sum      = {1'b0, ctrl_i.digest_len} + 8'd7;
  assign nw          = nw_sum[6:3];
  assign emit_last   = ({1'b0, k_q} == (nw - 4'd1));
  assign emit_go     = (state_q == bhe_pkg::ST_EMIT) && out_free;
  assign row         = (round_q >= bhe_pkg::SIGMA_ROWS) ? round_q - bhe_pkg::SIGMA_ROWS
                                                        : round_q;
  assign emit_word   = emit_last ?
      bhe_pkg::keep_bytes(h_q[k_q],
                          bhe_pkg::clamp_nb(ctrl_i.digest_len - {1'b0, k_q, 3'b000}))
      : h_q[k_q];

  // column steps on phases 0/1, diagonal steps on phases 2/3
  always_comb begin
    logic [3:0] ia, ib, ic, id, xs;
    bhe_pkg::g_out_t g;
    for (int i = 0; i < 16; i++) v_mix[i] = v_q[i];
    for (int j = 0; j < 4; j++) begin
      ia = 4'(j);
      ib = phase_q[1] ? 4'(4 + ((j + 1) % 4)) : 4'(4 + j);
      ic = phase_q[1] ? 4'(8 + ((j + 2) % 4)) : 4'(8 + j);
      id = phase_q[1] ? 4'(12 + ((j + 3) % 4)) : 4'(12 + j);
      xs = {phase_q[1], 2'(j), phase_q[0]};
      g  = bhe_pkg::g_half(v_q[ia], v_q[ib], v_q[ic], v_q[id],
                           m_q[bhe_pkg::SIGMA[row][xs]], phase_q[0]);
      v_mix[ia] = g.a;
      v_mix[ib] = g.b;
      v_mix[ic] = g.c;
      v_mix[id] = g.d;
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      bhe_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            bhe_pkg::CMD_KEY: begin
              pop_o   = 1'b1;
              state_d = cmd_i.key_last ? bhe_pkg::ST_PAD : bhe_pkg::ST_IDLE;
            end
            bhe_pkg::CMD_MSG: begin
              if (held_q) begin
                state_d = bhe_pkg::ST_INIT;
              end else begin
                pop_o   = 1'b1;
                state_d = cmd_i.finish ? bhe_pkg::ST_PAD : bhe_pkg::ST_IDLE;
              end
            end
            bhe_pkg::CMD_FIN: begin
              pop_o   = 1'b1;
              state_d = bhe_pkg::ST_PAD;
            end
            default: state_d = bhe_pkg::ST_IDLE;
          endcase
        end
      end
      bhe_pkg::ST_PAD: begin
        if (fill_q == bhe_pkg::BLOCK_WORDS) begin
          state_d = fin_q ? bhe_pkg::ST_INIT : bhe_pkg::ST_IDLE;
        end
      end
      bhe_pkg::ST_INIT: state_d = bhe_pkg::ST_MIX;
      bhe_pkg::ST_MIX: begin
        if (round_q == bhe_pkg::LAST_ROUND && phase_q == 2'd3) state_d = bhe_pkg::ST_FOLD;
      end
      bhe_pkg::ST_FOLD: state_d = last_q ? bhe_pkg::ST_EMIT : bhe_pkg::ST_IDLE;
      bhe_pkg::ST_EMIT: begin
        if (out_free && emit_last) state_d = bhe_pkg::ST_IDLE;
      end
      default: state_d = bhe_pkg::ST_IDLE;
    endcase
    if (ctrl_i.restart) begin
      state_d = bhe_pkg::ST_IDLE;
      pop_o   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bhe_pkg::ST_IDLE;
      fill_q      <= '0;
      held_q      <= 1'b0;
      fin_q       <= 1'b0;
      last_q      <= 1'b0;
      round_q     <= '0;
      phase_q     <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      h_q[0]      <= bhe_pkg::chain_init0(bhe_pkg::DIGEST_RESET, 7'd0);
      for (int i = 1; i < 8; i++) h_q[i] <= bhe_pkg::IV[i];
    end else if (ctrl_i.restart) begin
      state_q     <= bhe_pkg::ST_IDLE;
      fill_q      <= '0;
      held_q      <= 1'b0;
      fin_q       <= 1'b0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      h_q[0]      <= bhe_pkg::chain_init0(ctrl_i.digest_len_next, ctrl_i.key_len_next);
      for (int i = 1; i < 8; i++) h_q[i] <= bhe_pkg::IV[i];
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        bhe_pkg::ST_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.kind)
              bhe_pkg::CMD_KEY: begin
                fill_q <= fill_q + 5'd1;
                if (cmd_i.key_last) begin
                  cnt_q  <= bhe_pkg::KEY_BLOCK_BYTES;
                  held_q <= 1'b1;
                  fin_q  <= cmd_i.finish;
                  last_q <= 1'b1;
                end
              end
              bhe_pkg::CMD_MSG: begin
                if (held_q) begin
                  last_q <= 1'b0;
                end else begin
                  fill_q <= fill_q + 5'd1;
                  cnt_q  <= cnt_q + {60'd0, cmd_i.nb};
                  if (fill_q == bhe_pkg::BLOCK_WORDS - 5'd1) held_q <= 1'b1;
                  fin_q  <= cmd_i.finish;
                  last_q <= 1'b1;
                end
              end
              bhe_pkg::CMD_FIN: begin
                fin_q  <= 1'b1;
                last_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        bhe_pkg::ST_PAD: begin
          if (fill_q != bhe_pkg::BLOCK_WORDS) fill_q <= fill_q + 5'd1;
        end
        bhe_pkg::ST_INIT: begin
          round_q <= '0;
          phase_q <= '0;
        end
        bhe_pkg::ST_MIX: begin
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd3) round_q <= round_q + 4'd1;
        end
        bhe_pkg::ST_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
          if (!last_q) begin
            held_q <= 1'b0;
            fill_q <= '0;
          end
        end
        bhe_pkg::ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            k_q         <= k_q + 3'd1;
            if (emit_last) begin
              k_q    <= '0;
              cnt_q  <= '0;
              fill_q <= '0;
              held_q <= 1'b0;
              fin_q  <= 1'b0;
              h_q[0] <= bhe_pkg::chain_init0(ctrl_i.digest_len, ctrl_i.key_len);
              for (int i = 1; i < 8; i++) h_q[i] <= bhe_pkg::IV[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload: block words, work vector, output beat
  always_ff @(posedge clk_i) begin
    if (state_q == bhe_pkg::ST_IDLE && cmd_valid_i && !ctrl_i.restart &&
        (cmd_i.kind == bhe_pkg::CMD_KEY || (cmd_i.kind == bhe_pkg::CMD_MSG && !held_q))) begin
      m_q[fill_q[3:0]] <= cmd_i.word;
    end
    if (state_q == bhe_pkg::ST_PAD && fill_q != bhe_pkg::BLOCK_WORDS) begin
      m_q[fill_q[3:0]] <= '0;
    end
    if (state_q == bhe_pkg::ST_INIT) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i]   <= h_q[i];
        v_q[i+8] <= bhe_pkg::IV[i];
      end
      v_q[12] <= bhe_pkg::IV[4] ^ cnt_q;
      v_q[14] <= last_q ? ~bhe_pkg::IV[6] : bhe_pkg::IV[6];
    end
    if (state_q == bhe_pkg::ST_MIX) begin
      for (int i = 0; i < 16; i++) v_q[i] <= v_mix[i];
    end
    if (emit_go) begin
      out_q.digest_word      <= emit_word;
      out_q.word_number      <= k_q;
      out_q.last_digest_word <= emit_last;
    end
  end

endmodule

// ===== rtl/blake2b_hash_engine.sv =====
// ---------------------------------------------------------------------------
// blake2b_hash_engine
// Keyed or unkeyed BLAKE2b over a stream of 64-bit little-endian words.
// ---------------------------------------------------------------------------
// Channel   Dir  Beat payload                                    Accepted when
// cfg_i     in   index (0 digest_length, 1 key_length), value 7b valid && ready
// in_i      in   data_word, valid_bytes, end_of_message          valid && ready
// out_o     out  digest_word, word_number, last_digest_word      valid && ready
//
// A data beat is taken into a command queue and written to the block buffer
// by the back end when it pops the command; words stream at one a cycle while
// the back end is idle. Each compression runs dispatch, load, 48 half-G steps
// of four units and fold; a message end adds a zero-fill sweep and emits one
// digest word a cycle while out_o is ready. The input stalls only when the queue is full.
// Reset and a config write to index 0 or 1 restart the message; config is always ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module blake2b_hash_engine #(
  parameter int QueueDepth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bhe_cfg_if.sink  cfg_i,
  bhe_in_if.sink   in_i,
  bhe_out_if.source out_o
);
  logic [6:0]     digest_len_q, digest_len_d, key_len_q, key_len_d;
  logic           cfg_hit;
  bhe_pkg::ctrl_t ctrl;
  logic           push, push_ready, pop, pop_valid;
  bhe_pkg::cmd_t  push_cmd, pop_cmd;

  assign cfg_i.ready = 1'b1;
  // only the two listed registers restart the engine
  assign cfg_hit = cfg_i.valid &&
                   (cfg_i.data.index == bhe_pkg::CFG_IDX_DIGEST ||
                    cfg_i.data.index == bhe_pkg::CFG_IDX_KEY);

  always_comb begin
    digest_len_d = digest_len_q;
    key_len_d    = key_len_q;
    if (cfg_i.valid && cfg_i.data.index == bhe_pkg::CFG_IDX_DIGEST) begin
      if (cfg_i.data.value == '0)                     digest_len_d = 7'd1;
      else if (cfg_i.data.value > bhe_pkg::MAX_LEN)   digest_len_d = bhe_pkg::MAX_LEN;
      else                                            digest_len_d = cfg_i.data.value;
    end
    if (cfg_i.valid && cfg_i.data.index == bhe_pkg::CFG_IDX_KEY) begin
      key_len_d = (cfg_i.data.value > bhe_pkg::MAX_LEN) ? bhe_pkg::MAX_LEN
                                                        : cfg_i.data.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digest_len_q <= bhe_pkg::DIGEST_RESET;
      key_len_q    <= '0;
    end else begin
      digest_len_q <= digest_len_d;
      key_len_q    <= key_len_d;
    end
  end

  assign ctrl.restart         = cfg_hit;
  assign ctrl.digest_len      = digest_len_q;
  assign ctrl.key_len         = key_len_q;
  assign ctrl.digest_len_next = digest_len_d;
  assign ctrl.key_len_next    = key_len_d;

  bhe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_i         (in_i),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .push_ready_i (push_ready)
  );

  bhe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flush_i      (cfg_hit),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_cmd),
    .pop_i        (pop)
  );

  bhe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/bhe_checker.sv =====
// ---------------------------------------------------------------------------
// bhe_port_checker
// Port-level checks on the digest output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "blake2b_hash_engine_defines.svh"

module bhe_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input bhe_pkg::out_item_t out_data_i
);

  `BHE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "digest beat dropped or changed under stall")

  `BHE_ASSERT_NEXT(a_word_seq, out_valid_i && out_ready_i && !out_data_i.last_digest_word, out_valid_i && out_data_i.word_number == 3'($past(out_data_i.word_number) + 3'd1), "digest words not back to back in order")

  `BHE_ASSERT_NEXT(a_gap_after_last, out_valid_i && out_ready_i && out_data_i.last_digest_word, !out_valid_i, "digest beat right after last word")

endmodule

bind blake2b_hash_engine bhe_port_checker u_bhe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ===== sim/bhe_checker.sv =====
// ---------------------------------------------------------------------------
// bhe_checker
// Watches the config, word and digest channels of the hash engine, predicts
// each digest word and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhe_checker
  import bhe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bhe_cfg_if   cfg_m,
  bhe_in_if    in_m,
  bhe_out_if   out_m,
  output int   fails_o,
  output int   pending_o
);

  logic [6:0]  dig_len, key_len;
  logic [63:0] hv [8];
  logic [63:0] mw [16];
  logic [63:0] vw [16];
  logic [63:0] nbytes;
  int          fill;
  bit          keying, held;
  out_item_t   digest_q [$];

  assign pending_o = digest_q.size();

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] low_bytes(input logic [63:0] w, input int n);
    if (n >= 8) begin
      return w;
    end
    return w & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function void restart_msg();
    for (int i = 0; i < 8; i++) hv[i] = IV[i];
    hv[0] ^= 64'h0101_0000 ^ (64'(key_len) << 8) ^ 64'(dig_len);
    for (int i = 0; i < 16; i++) mw[i] = '0;
    nbytes = '0;
    fill   = 0;
    keying = (key_len != 0);
    held   = 0;
  endfunction

  function void gmix(input int a, input int b, input int c, input int d,
                     input logic [63:0] x, input logic [63:0] y);
    vw[a] = vw[a] + vw[b] + x;
    vw[d] = rotr(vw[d] ^ vw[a], 32);
    vw[c] = vw[c] + vw[d];
    vw[b] = rotr(vw[b] ^ vw[c], 24);
    vw[a] = vw[a] + vw[b] + y;
    vw[d] = rotr(vw[d] ^ vw[a], 16);
    vw[c] = vw[c] + vw[d];
    vw[b] = rotr(vw[b] ^ vw[c], 63);
  endfunction

  function void compress_block(input bit last);
    int s;
    for (int i = 0; i < 8; i++) begin
      vw[i]     = hv[i];
      vw[i + 8] = IV[i];
    end
    vw[12] ^= nbytes;
    if (last) vw[14] = ~vw[14];
    for (int r = 0; r < 12; r++) begin
      s = r % 10;
      gmix(0, 4, 8, 12,  mw[SIGMA[s][0]],  mw[SIGMA[s][1]]);
      gmix(1, 5, 9, 13,  mw[SIGMA[s][2]],  mw[SIGMA[s][3]]);
      gmix(2, 6, 10, 14, mw[SIGMA[s][4]],  mw[SIGMA[s][5]]);
      gmix(3, 7, 11, 15, mw[SIGMA[s][6]],  mw[SIGMA[s][7]]);
      gmix(0, 5, 10, 15, mw[SIGMA[s][8]],  mw[SIGMA[s][9]]);
      gmix(1, 6, 11, 12, mw[SIGMA[s][10]], mw[SIGMA[s][11]]);
      gmix(2, 7, 8, 13,  mw[SIGMA[s][12]], mw[SIGMA[s][13]]);
      gmix(3, 4, 9, 14,  mw[SIGMA[s][14]], mw[SIGMA[s][15]]);
    end
    for (int i = 0; i < 8; i++) hv[i] ^= vw[i] ^ vw[i + 8];
  endfunction

  function void emit_digest();
    int nw;
    out_item_t o;
    nw = (dig_len + 7) / 8;
    compress_block(1);
    for (int k = 0; k < nw; k++) begin
      o.digest_word      = (k == nw - 1) ? low_bytes(hv[k], dig_len - 8 * k) : hv[k];
      o.word_number      = k[2:0];
      o.last_digest_word = (k == nw - 1);
      digest_q.push_back(o);
    end
    restart_msg();
  endfunction

  function void absorb(input in_item_t it);
    int nb, kw;
    nb = (it.valid_bytes > 8) ? 8 : it.valid_bytes;
    if (keying) begin
      kw = (key_len + 7) / 8;
      mw[fill] = low_bytes(it.data_word, key_len - 8 * fill);
      fill++;
      if (fill >= kw || it.end_of_message) begin
        fill   = 16;
        held   = 1;
        nbytes = 64'd128;
        keying = 0;
      end
      if (it.end_of_message) emit_digest();
      return;
    end
    if (nb == 0) begin
      emit_digest();
      return;
    end
    if (held) begin
      compress_block(0);
      for (int i = 0; i < 16; i++) mw[i] = '0;
      fill = 0;
      held = 0;
    end
    mw[fill] = low_bytes(it.data_word, nb);
    fill++;
    nbytes += 64'(nb);
    if (fill == 16) held = 1;
    if (it.end_of_message || nb < 8) emit_digest();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_len = DIGEST_RESET;
      key_len = '0;
      restart_msg();
      digest_q.delete();
      fails_o = 0;
    end else begin
      if (cfg_m.valid && cfg_m.ready) begin
        if (cfg_m.data.index == CFG_IDX_DIGEST) begin
          dig_len = (cfg_m.data.value == 0) ? 7'd1 :
                    (cfg_m.data.value > MAX_LEN) ? MAX_LEN : cfg_m.data.value;
          restart_msg();
        end else if (cfg_m.data.index == CFG_IDX_KEY) begin
          key_len = (cfg_m.data.value > MAX_LEN) ? MAX_LEN : cfg_m.data.value;
          restart_msg();
        end
      end
      if (in_m.valid && in_m.ready) absorb(in_m.data);
      if (out_m.valid && out_m.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat: expected none, actual %h", $time,
                   out_m.data);
          fails_o++;
        end else begin
          out_item_t e;
          e = digest_q.pop_front();
          if (e.digest_word !== out_m.data.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     e.digest_word, out_m.data.digest_word);
            fails_o++;
          end
          if (e.word_number !== out_m.data.word_number) begin
            $display("%0t: word_number expected %0d actual %0d", $time,
                     e.word_number, out_m.data.word_number);
            fails_o++;
          end
          if (e.last_digest_word !== out_m.data.last_digest_word) begin
            $display("%0t: last_digest_word expected %0d actual %0d", $time,
                     e.last_digest_word, out_m.data.last_digest_word);
            fails_o++;
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the BLAKE2b hash engine: directed corner messages, then random
// keyed and unkeyed messages over several digest/key settings, with random
// stalls on both channels. The checker predicts and compares every digest beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bhe_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;

  bhe_cfg_if cfg_if ();
  bhe_in_if  in_if ();
  bhe_out_if out_if ();

  int fails, pending;
  int sent = 0;
  int wd = 0;
  bit calm = 0;      // no idling on either side in the closing part
  bit hold_req = 0;  // asks the receiver for one long hold-off
  int kl = 0;        // key length currently programmed, clamped

  blake2b_hash_engine dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  bhe_checker chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_m    (cfg_if),
    .in_m     (in_if),
    .out_m    (out_if),
    .fails_o  (fails),
    .pending_o(pending)
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Watchdog: cycles without any beat on any channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      wd <= 0;
    end else begin
      wd <= wd + 1;
    end
    if (wd > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Digest receiver: random stall bursts, plus one long hold when asked.
  initial begin
    out_if.ready = 1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
        out_if.ready <= 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_if.ready <= 1;
      end
    end
  end

  // One data beat; valid stays high after acceptance until a gap or a drain lowers it.
  task automatic send_word(input logic [63:0] w, input logic [3:0] nb, input logic eom);
    in_item_t it;
    it.data_word      = w;
    it.valid_bytes    = nb;
    it.end_of_message = eom;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Wait for all digest words, then for the back end to settle.
  task automatic drain();
    in_if.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_item_t c;
    drain();
    c.index = idx;
    c.value = val;
    cfg_if.valid <= 1;
    cfg_if.data  <= c;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 0;
    if (idx == CFG_IDX_KEY) kl = (val > MAX_LEN) ? MAX_LEN : val;
  endtask

  // Well-formed message: key words, nwords message words, last one short or full, or full plus an empty word.
  task automatic send_msg(input int nwords, input bit zero_end);
    int kw;
    kw = (kl + 7) / 8;
    for (int i = 0; i < kw; i++)
      send_word(rand64(), 4'($urandom_range(0, 15)), (nwords == 0) && (i == kw - 1));
    if (kw == 0 && nwords == 0) begin
      send_word(rand64(), 4'd0, 1'b1);
      return;
    end
    for (int i = 0; i < nwords; i++) begin
      if (i < nwords - 1) begin
        send_word(rand64(), 4'd8, 1'b0);
      end else if (zero_end) begin
        send_word(rand64(), 4'd8, 1'b0);
        send_word(rand64(), 4'd0, $urandom_range(0, 1));
      end else begin
        send_word(rand64(), 4'($urandom_range(1, 8)), 1'b1);
      end
    end
  endtask

  // Broken sequences: early key end, oversized counts, short mid-message words.
  task automatic send_noise();
    repeat ($urandom_range(1, 5))
      send_word(rand64(), 4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0);
    if (kl != 0) send_word(rand64(), 4'd8, 1'b1);
    send_word(rand64(), 4'd0, 1'b1);
  endtask

  task automatic random_msg();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)      send_noise();
    else if (r == 1) send_msg($urandom_range(30, 34), $urandom_range(0, 1));
    else             send_msg($urandom_range(0, 20), $urandom_range(0, 4) == 0);
  endtask

  initial begin
    cfg_if.valid = 0;
    cfg_if.data  = '0;
    in_if.valid  = 0;
    in_if.data   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset settings, empty / exact block / one word plus an empty closing word.
    send_msg(0, 0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);  // count above 8 taken as 8
    send_word(64'h0, 4'd3, 1'b0);                     // short word ends message
    send_msg(16, 0);
    send_msg(1, 1);
    // Keyed, with the key ended early by an end-of-message on a key word.
    write_reg(CFG_IDX_KEY, 7'd64);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
    send_word(64'h0, 4'd8, 1'b1);
    send_msg(0, 0);
    // Register clamping: zero digest, oversized digest and key, unused index.
    write_reg(CFG_IDX_DIGEST, 7'd0);
    send_msg(1, 0);
    write_reg(CFG_IDX_DIGEST, 7'd127);
    write_reg(CFG_IDX_KEY, 7'd127);
    send_msg(2, 0);
    write_reg(2'd3, 7'd5);
    send_msg(1, 0);

    // Random phases over several settings.
    while (sent < 350) begin
      write_reg(CFG_IDX_DIGEST, 7'($urandom_range(0, 3) == 0 ? 64 : $urandom_range(1, 64)));
      write_reg(CFG_IDX_KEY, 7'($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 64)));
      repeat ($urandom_range(3, 6)) random_msg();
      if (sent > 150 && sent < 250 && !hold_req) begin
        // long receiver hold while several short messages pile up
        hold_req = 1;
        repeat (6) send_msg(2, 0);
      end
    end
    write_reg(CFG_IDX_KEY, 7'd1);
    write_reg(CFG_IDX_DIGEST, 7'd64);
    calm = 1;
    while (sent < 410) random_msg();

    drain();
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
